// ----- src/kml_pkg.sv -----
// ----------------------------------------------------------------------------
// kml_pkg
// Shared types and constants for the k-means clustering block.
// ----------------------------------------------------------------------------
package kml_pkg;

  localparam int MAX_POINTS   = 256;
  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_DIM      = 64;

  localparam int PT_W   = $clog2(MAX_POINTS);
  localparam int CL_W   = $clog2(MAX_CLUSTERS);
  localparam int DIM_W  = $clog2(MAX_DIM);
  localparam int N_W    = 9;
  localparam int K_W    = 5;
  localparam int D_W    = 7;
  localparam int P_W    = 7;
  localparam int CNT_W  = 9;
  localparam int CV_W   = 24;
  localparam int SQ_W   = 48;
  localparam int DIST_W = 54;
  localparam int DIVD_W = 32;

  localparam logic [2:0] REQ_WR_POINT  = 3'd0;
  localparam logic [2:0] REQ_WR_CENT   = 3'd1;
  localparam logic [2:0] REQ_RUN       = 3'd2;
  localparam logic [2:0] REQ_RD_ASSIGN = 3'd3;
  localparam logic [2:0] REQ_RD_CENT   = 3'd4;

  localparam logic [1:0] CFG_POINT_COUNT   = 2'd0;
  localparam logic [1:0] CFG_CLUSTER_COUNT = 2'd1;
  localparam logic [1:0] CFG_VECTOR_LENGTH = 2'd2;
  localparam logic [1:0] CFG_PASS_COUNT    = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  entry_index;
    logic [5:0]  coord_index;
    logic [15:0] coord_value;
    logic [15:0] item_id;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  cluster_index;
    logic        unassigned;
    logic [23:0] centroid_value;
    logic [15:0] centroid_id;
  } out_t;

  typedef struct packed {
    logic [N_W-1:0] n;
    logic [K_W-1:0] k;
    logic [D_W-1:0] d;
    logic [P_W-1:0] passes;
  } cfg_t;

  typedef struct packed {
    logic             latch_req;
    logic             mem_op;
    logic             resp;
    logic             skip_wr;
    logic             dist_issue;
    logic             dist_last;
    logic             acc_issue;
    logic             assign_wr;
    logic             clr_counts;
    logic             div_start;
    logic             upd_wr;
    logic             id_clr;
    logic [PT_W-1:0]  i;
    logic [CL_W-1:0]  j;
    logic [DIM_W-1:0] c;
  } cmd_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic       skip;
    logic       count_zero;
    logic       div_done;
    logic       out_free;
  } stat_t;

endpackage

// ----- src/kmeans_lloyd_clustering.sv -----
// ----------------------------------------------------------------------------
// kmeans_lloyd_clustering
// Lloyd k-means over up to 256 points, 16 clusters and 64 coordinates.
//
// Requests enter on the in_ channel (valid/ready) as one word each: point or
// centroid coordinate writes, a run, and assignment or centroid reads. Every
// request gives one result word on the out_ channel (valid/ready).
// Loads and reads pass from acceptance through the S_MEM and S_RESP states
// to their result; one request is handled at a time. A run steps each pass
// through the distance and accumulation loop, one coordinate per cycle
// through the point and centroid memory ports; between passes the
// bit-serial divider updates every coordinate of every non-empty cluster.
// cfg_we writes the register picked by cfg_index (point_count, cluster_count,
// vector_length, pass_count); write only while idle. Reset brings them to
// 256, 16, 64, 8 and marks every point unassigned; stores are undefined until
// loaded. If the receiver stalls, the result word holds; one more request is
// accepted and its result waits until that word is taken.
// ----------------------------------------------------------------------------
module kmeans_lloyd_clustering (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  kml_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output kml_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [8:0]    cfg_wdata
);

  logic [kml_pkg::N_W-1:0] n_r;
  logic [kml_pkg::K_W-1:0] k_r;
  logic [kml_pkg::D_W-1:0] d_r;
  logic [kml_pkg::P_W-1:0] p_r;
  kml_pkg::cfg_t           cfg;
  kml_pkg::cmd_t           cmd;
  kml_pkg::stat_t          stat;
  logic                    rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= kml_pkg::N_W'(kml_pkg::MAX_POINTS);
      k_r <= kml_pkg::K_W'(kml_pkg::MAX_CLUSTERS);
      d_r <= kml_pkg::D_W'(kml_pkg::MAX_DIM);
      p_r <= kml_pkg::P_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        kml_pkg::CFG_POINT_COUNT:   n_r <= cfg_wdata[kml_pkg::N_W-1:0];
        kml_pkg::CFG_CLUSTER_COUNT: k_r <= cfg_wdata[kml_pkg::K_W-1:0];
        kml_pkg::CFG_VECTOR_LENGTH: d_r <= cfg_wdata[kml_pkg::D_W-1:0];
        kml_pkg::CFG_PASS_COUNT:    p_r <= cfg_wdata[kml_pkg::P_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.n = (n_r == '0) ? kml_pkg::N_W'(1) :
            (n_r > kml_pkg::N_W'(kml_pkg::MAX_POINTS)) ?
            kml_pkg::N_W'(kml_pkg::MAX_POINTS) : n_r;
    cfg.k = (k_r == '0) ? kml_pkg::K_W'(1) :
            (k_r > kml_pkg::K_W'(kml_pkg::MAX_CLUSTERS)) ?
            kml_pkg::K_W'(kml_pkg::MAX_CLUSTERS) : k_r;
    cfg.d = (d_r == '0) ? kml_pkg::D_W'(1) :
            (d_r > kml_pkg::D_W'(kml_pkg::MAX_DIM)) ?
            kml_pkg::D_W'(kml_pkg::MAX_DIM) : d_r;
    cfg.passes = (p_r == '0) ? kml_pkg::P_W'(1) : p_r;
  end

  assign in_ready = rdy;

  kml_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (rdy),
    .cfg      (cfg),
    .stat     (stat),
    .cmd      (cmd)
  );

  kml_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg       (cfg),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ----- src/kml_div.sv -----
// ----------------------------------------------------------------------------
// kml_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kml_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [kml_pkg::DIVD_W-1:0] dividend,
  input  logic [kml_pkg::CNT_W-1:0]  divisor,
  output logic [kml_pkg::DIVD_W-1:0] quot,
  output logic                       done
);

  localparam int SC_W = $clog2(kml_pkg::DIVD_W);

  logic                       busy_r, done_r;
  logic [SC_W-1:0]            step_r;
  logic [kml_pkg::CNT_W-1:0]  rem_r, div_r;
  logic [kml_pkg::DIVD_W-1:0] quot_r;
  logic [kml_pkg::CNT_W:0]    rem_sh, rem_sub;

  assign rem_sh  = {rem_r, quot_r[kml_pkg::DIVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == SC_W'(kml_pkg::DIVD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      div_r  <= divisor;
      quot_r <= dividend;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, div_r}) begin
        rem_r  <= rem_sub[kml_pkg::CNT_W-1:0];
        quot_r <= {quot_r[kml_pkg::DIVD_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[kml_pkg::CNT_W-1:0];
        quot_r <= {quot_r[kml_pkg::DIVD_W-2:0], 1'b0};
      end
    end
  end

  assign quot = quot_r;
  assign done = done_r;

endmodule

// ----- src/kml_dpath.sv -----
// ----------------------------------------------------------------------------
// kml_dpath
// Stores, distance pipeline, accumulation and centroid update datapath.
// ----------------------------------------------------------------------------
module kml_dpath (
  input  logic            clk,
  input  logic            rst_n,
  input  kml_pkg::in_t    in_data,
  input  logic            out_ready,
  output logic            out_valid,
  output kml_pkg::out_t   out_data,
  input  kml_pkg::cfg_t   cfg,
  input  kml_pkg::cmd_t   cmd,
  output kml_pkg::stat_t  stat
);

  localparam int PA_W = kml_pkg::PT_W + kml_pkg::DIM_W;
  localparam int CA_W = kml_pkg::CL_W + kml_pkg::DIM_W;

  kml_pkg::in_t  req_r;
  kml_pkg::out_t out_r, out_nxt;
  logic          out_valid_r;

  logic [15:0]               pmem [kml_pkg::MAX_POINTS*kml_pkg::MAX_DIM];
  logic [15:0]               pid_mem [kml_pkg::MAX_POINTS];
  logic [kml_pkg::CV_W-1:0]  cmem [kml_pkg::MAX_CLUSTERS*kml_pkg::MAX_DIM];
  logic [kml_pkg::CV_W-1:0]  smem [kml_pkg::MAX_CLUSTERS*kml_pkg::MAX_DIM];
  logic [kml_pkg::CL_W-1:0]  asg_mem [kml_pkg::MAX_POINTS];
  logic [15:0]               cid_r [kml_pkg::MAX_CLUSTERS];
  logic [kml_pkg::CNT_W-1:0] cnt_r [kml_pkg::MAX_CLUSTERS];
  logic [kml_pkg::MAX_POINTS-1:0] assigned_r;

  logic [15:0]               pm_q, pid_q;
  logic [kml_pkg::CV_W-1:0]  cm_q, sm_q;
  logic [kml_pkg::CL_W-1:0]  asg_q;

  logic [kml_pkg::CL_W-1:0]  cent;
  logic                      pt_bad, cent_bad, coord_bad;
  logic                      wr_pt, wr_cent;

  logic                      s1_v_r, s1_last_r, s2_v_r, s2_last_r;
  logic [kml_pkg::CL_W-1:0]  s1_j_r, s2_j_r, best_r;
  logic [kml_pkg::CV_W-1:0]  a_val, diff;
  logic [kml_pkg::SQ_W-1:0]  sq_r;
  logic [kml_pkg::DIST_W-1:0] dist_r, best_dist_r, total;

  logic                      acc_wv_r;
  logic [CA_W-1:0]           acc_wa_r;
  logic [kml_pkg::CV_W-1:0]  acc_sum;

  logic [kml_pkg::DIVD_W-1:0] quot;
  logic                      div_done;
  logic                      skip;

  assign cent      = req_r.entry_index[kml_pkg::CL_W-1:0];
  assign pt_bad    = {1'b0, req_r.entry_index} >= cfg.n;
  assign cent_bad  = {1'b0, cent} >= cfg.k;
  assign coord_bad = {1'b0, req_r.coord_index} >= cfg.d;
  assign wr_pt     = cmd.mem_op && (req_r.req_type == kml_pkg::REQ_WR_POINT) &&
                     !pt_bad && !coord_bad;
  assign wr_cent   = cmd.mem_op && (req_r.req_type == kml_pkg::REQ_WR_CENT) &&
                     !cent_bad && !coord_bad;

  always_ff @(posedge clk) begin
    if (cmd.latch_req) req_r <= in_data;
  end

  // point coordinates and ids
  always_ff @(posedge clk) begin
    if (wr_pt) begin
      pmem[{req_r.entry_index, req_r.coord_index}] <= req_r.coord_value;
      pid_mem[req_r.entry_index] <= req_r.item_id;
    end
    pm_q  <= pmem[PA_W'({cmd.i, cmd.c})];
    pid_q <= pid_mem[cmd.i];
  end

  // centroid coordinates
  always_ff @(posedge clk) begin
    if (wr_cent) cmem[{cent, req_r.coord_index}] <= {req_r.coord_value, 8'd0};
    else if (cmd.upd_wr) cmem[{cmd.j, cmd.c}] <= quot[kml_pkg::CV_W-1:0];
    if (cmd.dist_issue) cm_q <= cmem[{cmd.j, cmd.c}];
    else cm_q <= cmem[{cent, req_r.coord_index}];
  end

  always_ff @(posedge clk) begin
    if (wr_cent) cid_r[cent] <= req_r.item_id;
    else if (cmd.id_clr) cid_r[cmd.j] <= 16'd0;
  end

  // distance pipeline
  assign a_val = {pm_q, 8'd0};
  assign diff  = (a_val > cm_q) ? a_val - cm_q : cm_q - a_val;
  assign total = dist_r + {{(kml_pkg::DIST_W-kml_pkg::SQ_W){1'b0}}, sq_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      dist_r <= '0;
    end else begin
      s1_v_r <= cmd.dist_issue;
      s2_v_r <= s1_v_r;
      if (s2_v_r) begin
        if (s2_last_r) dist_r <= '0;
        else dist_r <= total;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r <= cmd.dist_last;
    s1_j_r    <= cmd.j;
    s2_last_r <= s1_last_r;
    s2_j_r    <= s1_j_r;
    sq_r      <= diff * diff;
    if (s2_v_r && s2_last_r && ((s2_j_r == '0) || (total < best_dist_r))) begin
      best_dist_r <= total;
      best_r      <= s2_j_r;
    end
  end

  // cluster sums: a row is live once its count is non-zero
  assign acc_sum = (cnt_r[acc_wa_r[CA_W-1 -: kml_pkg::CL_W]] == '0) ?
                   {8'd0, pm_q} : sm_q + {8'd0, pm_q};

  always_ff @(posedge clk) begin
    if (!rst_n) acc_wv_r <= 1'b0;
    else acc_wv_r <= cmd.acc_issue;
  end

  always_ff @(posedge clk) begin
    acc_wa_r <= {best_r, cmd.c};
    if (acc_wv_r) smem[acc_wa_r] <= acc_sum;
    if (cmd.acc_issue) sm_q <= smem[{best_r, cmd.c}];
    else sm_q <= smem[{cmd.j, cmd.c}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < kml_pkg::MAX_CLUSTERS; m++) cnt_r[m] <= '0;
    end else if (cmd.clr_counts) begin
      for (int m = 0; m < kml_pkg::MAX_CLUSTERS; m++) cnt_r[m] <= '0;
    end else if (cmd.assign_wr) begin
      cnt_r[best_r] <= cnt_r[best_r] + 1'b1;
    end
  end

  // assignments
  always_ff @(posedge clk) begin
    if (cmd.assign_wr) asg_mem[cmd.i] <= best_r;
    asg_q <= asg_mem[req_r.entry_index];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) assigned_r <= '0;
    else if (cmd.assign_wr) assigned_r[cmd.i] <= 1'b1;
    else if (cmd.skip_wr) assigned_r[cmd.i] <= 1'b0;
  end

  always_comb begin
    skip = 1'b0;
    for (int m = 0; m < kml_pkg::MAX_CLUSTERS; m++) begin
      if ((kml_pkg::K_W'(m) < cfg.k) && (cid_r[m] == pid_q)) skip = 1'b1;
    end
    skip = skip && (pid_q != 16'd0);
  end

  kml_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({sm_q, 8'd0}),
    .divisor  (cnt_r[cmd.j]),
    .quot     (quot),
    .done     (div_done)
  );

  // result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.resp) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    out_nxt = '0;
    unique case (req_r.req_type)
      kml_pkg::REQ_WR_POINT: out_nxt.status = pt_bad | coord_bad;
      kml_pkg::REQ_WR_CENT:  out_nxt.status = cent_bad | coord_bad;
      kml_pkg::REQ_RD_ASSIGN: begin
        if (pt_bad) out_nxt.status = 1'b1;
        else if (!assigned_r[req_r.entry_index]) out_nxt.unassigned = 1'b1;
        else out_nxt.cluster_index = asg_q;
      end
      kml_pkg::REQ_RD_CENT: begin
        if (cent_bad || coord_bad) begin
          out_nxt.status = 1'b1;
        end else begin
          out_nxt.centroid_value = cm_q;
          out_nxt.centroid_id    = cid_r[cent];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) out_r <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_r;
  assign stat.req_type   = req_r.req_type;
  assign stat.skip       = skip;
  assign stat.count_zero = cnt_r[cmd.j] == '0;
  assign stat.div_done   = div_done;
  assign stat.out_free   = !out_valid_r || out_ready;

endmodule

// ----- src/kml_ctrl.sv -----
// ----------------------------------------------------------------------------
// kml_ctrl
// Request sequencer: load/read handling and the Lloyd pass loop.
// ----------------------------------------------------------------------------
module kml_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  kml_pkg::cfg_t  cfg,
  input  kml_pkg::stat_t stat,
  output kml_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_MEM, S_RESP, S_PASS, S_PID, S_SKIP, S_DIST, S_DRAIN,
    S_ACC, S_ACCW, S_ASSIGN, S_UJ, S_URD, S_UST, S_UWT
  } state_t;

  state_t                      state_r, state_nxt;
  logic [kml_pkg::PT_W-1:0]    i_r, i_nxt;
  logic [kml_pkg::CL_W-1:0]    j_r, j_nxt;
  logic [kml_pkg::DIM_W-1:0]   c_r, c_nxt;
  logic [kml_pkg::P_W-1:0]     pass_r, pass_nxt;
  logic [1:0]                  wait_r, wait_nxt;
  logic                        i_last, j_last, c_last, pass_last;
  logic                        skip_hold_r;

  assign i_last    = {1'b0, i_r} == cfg.n - 1'b1;
  assign j_last    = {1'b0, j_r} == cfg.k - 1'b1;
  assign c_last    = {1'b0, c_r} == cfg.d - 1'b1;
  assign pass_last = pass_r == cfg.passes - 1'b1;
  assign in_ready  = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    c_nxt     = c_r;
    pass_nxt  = pass_r;
    wait_nxt  = wait_r;
    cmd       = '0;
    cmd.i     = i_r;
    cmd.j     = j_r;
    cmd.c     = c_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.latch_req = in_valid;
        if (in_valid) state_nxt = S_MEM;
      end
      S_MEM: begin
        cmd.mem_op = 1'b1;
        if (stat.req_type == kml_pkg::REQ_RUN) begin
          pass_nxt  = '0;
          state_nxt = S_PASS;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.resp  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_PASS: begin
        cmd.clr_counts = 1'b1;
        i_nxt          = '0;
        state_nxt      = S_PID;
      end
      S_PID: state_nxt = S_SKIP;
      S_SKIP: begin
        if (stat.skip) begin
          cmd.skip_wr = 1'b1;
          state_nxt   = S_ASSIGN;
        end else begin
          j_nxt     = '0;
          c_nxt     = '0;
          state_nxt = S_DIST;
        end
      end
      S_DIST: begin
        cmd.dist_issue = 1'b1;
        cmd.dist_last  = c_last;
        if (c_last) begin
          c_nxt = '0;
          if (j_last) begin
            wait_nxt  = '0;
            state_nxt = S_DRAIN;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end else begin
          c_nxt = c_r + 1'b1;
        end
      end
      S_DRAIN: begin
        wait_nxt = wait_r + 1'b1;
        if (wait_r == 2'd3) begin
          c_nxt     = '0;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc_issue = 1'b1;
        if (c_last) begin
          c_nxt     = '0;
          state_nxt = S_ACCW;
        end else begin
          c_nxt = c_r + 1'b1;
        end
      end
      S_ACCW: state_nxt = S_ASSIGN;
      S_ASSIGN: begin
        // reached from a skipped point too; only a real assignment counts
        cmd.assign_wr = !skip_hold_r;
        if (i_last) begin
          if (pass_last) begin
            state_nxt = S_RESP;
          end else begin
            j_nxt     = '0;
            state_nxt = S_UJ;
          end
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_PID;
        end
      end
      S_UJ: begin
        if (stat.count_zero) begin
          if (j_last) begin
            pass_nxt  = pass_r + 1'b1;
            state_nxt = S_PASS;
          end else begin
            j_nxt = j_r + 1'b1;
          end
        end else begin
          c_nxt     = '0;
          state_nxt = S_URD;
        end
      end
      S_URD: state_nxt = S_UST;
      S_UST: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_UWT;
      end
      S_UWT: begin
        if (stat.div_done) begin
          cmd.upd_wr = 1'b1;
          if (c_last) begin
            cmd.id_clr = 1'b1;
            if (j_last) begin
              pass_nxt  = pass_r + 1'b1;
              state_nxt = S_PASS;
            end else begin
              j_nxt     = j_r + 1'b1;
              state_nxt = S_UJ;
            end
          end else begin
            c_nxt     = c_r + 1'b1;
            state_nxt = S_URD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      c_r         <= '0;
      pass_r      <= '0;
      wait_r      <= '0;
      skip_hold_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      c_r         <= c_nxt;
      pass_r      <= pass_nxt;
      wait_r      <= wait_nxt;
      skip_hold_r <= cmd.skip_wr;
    end
  end

endmodule

// ----- sim/kmeans_lloyd_clustering_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmeans_lloyd_clustering_test
// Self-checking bench for the Lloyd k-means block. A directed table covers
// range errors, unused codes, id skipping, ties and empty clusters; random
// loads, runs and reads follow under several register settings. Every result
// word is checked field by field against the table or a behavioural model kept
// in the bench, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module kmeans_lloyd_clustering_test;
  import kml_pkg::*;

  localparam logic [2:0] REQ_BAD5 = 3'd5;
  localparam logic [2:0] REQ_BAD7 = 3'd7;
  localparam int LIMIT = 2000000;

  typedef struct {
    in_t  req;
    bit   known;
    out_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_wdata = '0;

  // model state
  logic [15:0] pts [0:255][0:63];
  logic [15:0] pid [0:255];
  logic [23:0] cen [0:15][0:63];
  logic [15:0] cid [0:15];
  logic [3:0]  asg [0:255];
  bit          asg_none [0:255];
  bit          pt_ok [0:255][0:63];
  bit          cen_ok [0:15][0:63];
  longint unsigned sums [0:15][0:63];
  int          members [0:15];
  int          reg_n = 256, reg_k = 16, reg_d = 64, reg_p = 8;

  out_t pending [$];
  row_t table_rows [$];
  int   errors = 0, words = 0, runs = 0, settings = 0, cycles = 0;
  int   hold_at = -1;
  bit   quiet = 1'b0, hold_req = 1'b0;

  kmeans_lloyd_clustering dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int clamp(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void lloyd_passes();
    int n, k, d, passes, best;
    bit skip;
    longint unsigned a, b, diff, sq_sum, best_sq;
    n = clamp(reg_n, MAX_POINTS);
    k = clamp(reg_k, MAX_CLUSTERS);
    d = clamp(reg_d, MAX_DIM);
    passes = (reg_p == 0) ? 1 : reg_p;
    for (int p = 0; p < passes; p++) begin
      for (int j = 0; j < k; j++) begin
        members[j] = 0;
        for (int c = 0; c < d; c++) sums[j][c] = 0;
      end
      for (int i = 0; i < n; i++) begin
        skip = 1'b0;
        if (pid[i] != 0)
          for (int j = 0; j < k; j++) if (cid[j] == pid[i]) skip = 1'b1;
        if (skip) begin
          asg_none[i] = 1'b1;
          asg[i] = 0;
          continue;
        end
        best = 0;
        best_sq = 0;
        for (int j = 0; j < k; j++) begin
          sq_sum = 0;
          for (int c = 0; c < d; c++) begin
            a = longint'(pts[i][c]) << 8;
            b = longint'(cen[j][c]);
            diff = (a > b) ? a - b : b - a;
            sq_sum += diff * diff;
          end
          if (j == 0 || sq_sum < best_sq) begin
            best_sq = sq_sum;
            best = j;
          end
        end
        asg_none[i] = 1'b0;
        asg[i] = best[3:0];
        members[best]++;
        for (int c = 0; c < d; c++) sums[best][c] += pts[i][c];
      end
      if (p + 1 < passes)
        for (int j = 0; j < k; j++) begin
          if (members[j] == 0) continue;
          for (int c = 0; c < d; c++)
            cen[j][c] = 24'((sums[j][c] << 8) / longint'(members[j]));
          cid[j] = 0;
        end
    end
  endfunction

  function automatic out_t cluster_response(in_t x);
    out_t r;
    int n, k, d, e, ci, co;
    r = '0;
    n = clamp(reg_n, MAX_POINTS);
    k = clamp(reg_k, MAX_CLUSTERS);
    d = clamp(reg_d, MAX_DIM);
    e = x.entry_index;
    ci = x.entry_index[3:0];
    co = x.coord_index;
    case (x.req_type)
      REQ_WR_POINT: begin
        if (e >= n || co >= d) r.status = 1'b1;
        else begin
          pts[e][co] = x.coord_value;
          pid[e] = x.item_id;
          pt_ok[e][co] = 1'b1;
        end
      end
      REQ_WR_CENT: begin
        if (ci >= k || co >= d) r.status = 1'b1;
        else begin
          cen[ci][co] = {x.coord_value, 8'h00};
          cid[ci] = x.item_id;
          cen_ok[ci][co] = 1'b1;
        end
      end
      REQ_RUN: begin
        lloyd_passes();
        runs++;
      end
      REQ_RD_ASSIGN: begin
        if (e >= n) r.status = 1'b1;
        else if (asg_none[e]) r.unassigned = 1'b1;
        else r.cluster_index = asg[e];
      end
      REQ_RD_CENT: begin
        if (ci >= k || co >= d) r.status = 1'b1;
        else begin
          r.centroid_value = cen[ci][co];
          r.centroid_id = cid[ci];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit data_loaded();
    for (int i = 0; i < clamp(reg_n, MAX_POINTS); i++)
      for (int c = 0; c < clamp(reg_d, MAX_DIM); c++) if (!pt_ok[i][c]) return 1'b0;
    for (int j = 0; j < clamp(reg_k, MAX_CLUSTERS); j++)
      for (int c = 0; c < clamp(reg_d, MAX_DIM); c++) if (!cen_ok[j][c]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic in_t mk_req(logic [2:0] t, logic [7:0] e, logic [5:0] c,
                                 logic [15:0] v, logic [15:0] id);
    in_t x;
    x.req_type = t;
    x.entry_index = e;
    x.coord_index = c;
    x.coord_value = v;
    x.item_id = id;
    return x;
  endfunction

  function automatic out_t mk_resp(bit st, logic [3:0] cl, bit un);
    out_t r;
    r = '0;
    r.status = st;
    r.cluster_index = cl;
    r.unassigned = un;
    return r;
  endfunction

  function automatic void add_row(in_t x, bit known, out_t w);
    row_t r;
    r.req = x;
    r.known = known;
    r.want = w;
    table_rows.insert(table_rows.size(), r);
  endfunction

  function automatic logic [15:0] rand_coord();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
  endfunction

  function automatic logic [15:0] rand_id();
    return ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
  endfunction

  function automatic in_t rand_req();
    int n, k, d, r;
    logic [7:0] e;
    logic [5:0] c;
    n = clamp(reg_n, MAX_POINTS);
    k = clamp(reg_k, MAX_CLUSTERS);
    d = clamp(reg_d, MAX_DIM);
    r = $urandom_range(0, 99);
    c = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, d - 1));
    if (r < 30) begin
      e = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, n - 1));
      return mk_req(REQ_WR_POINT, e, c, rand_coord(), rand_id());
    end
    if (r < 45 || r >= 75 && r < 97) begin
      e[7:4] = 4'($urandom);
      e[3:0] = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, k - 1));
      if (r < 45) return mk_req(REQ_WR_CENT, e, c, rand_coord(), rand_id());
      if (e[3:0] >= k || c >= d || cen_ok[e[3:0]][c])
        return mk_req(REQ_RD_CENT, e, c, 16'($urandom), 16'($urandom));
    end
    if (r >= 45 && r < 50 && data_loaded())
      return mk_req(REQ_RUN, 8'($urandom), 6'($urandom), 16'($urandom), 16'($urandom));
    if (r >= 97)
      return mk_req(3'($urandom_range(5, 7)), 8'($urandom), 6'($urandom),
                    16'($urandom), 16'($urandom));
    e = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, n - 1));
    return mk_req(REQ_RD_ASSIGN, e, 6'($urandom), 16'($urandom), 16'($urandom));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send(in_t x, bit known, out_t w);
    out_t p;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (!in_ready);
    p = cluster_response(x);
    pending.insert(pending.size(), known ? w : p);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_put(logic [1:0] idx, int v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 9'(v);
    @(negedge clk);
  endtask

  task automatic set_regs(int n, int k, int d, int p);
    cfg_put(CFG_POINT_COUNT, n);
    cfg_put(CFG_CLUSTER_COUNT, k);
    cfg_put(CFG_VECTOR_LENGTH, d);
    cfg_put(CFG_PASS_COUNT, p);
    cfg_we <= 1'b0;
    reg_n = n;
    reg_k = k;
    reg_d = d;
    reg_p = p;
    settings++;
  endtask

  task automatic load_missing();
    for (int i = 0; i < reg_n; i++)
      for (int c = 0; c < reg_d; c++)
        if (!pt_ok[i][c])
          send(mk_req(REQ_WR_POINT, 8'(i), 6'(c), rand_coord(), rand_id()), 1'b0, '0);
    for (int j = 0; j < reg_k; j++)
      for (int c = 0; c < reg_d; c++)
        if (!cen_ok[j][c])
          send(mk_req(REQ_WR_CENT, 8'(j), 6'(c), rand_coord(), rand_id()), 1'b0, '0);
  endtask

  task automatic random_phase(int n, int k, int d, int p, int count);
    drain();
    set_regs(n, k, d, p);
    load_missing();
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_req = 1'b1;
      send(rand_req(), 1'b0, '0);
    end
  endtask

  // receiver
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      words++;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %h", out_data);
        errors++;
      end else begin
        exp_w = pending.pop_front();
        if (out_data.status !== exp_w.status) begin
          $error("status exp %0h got %0h", exp_w.status, out_data.status);
          errors++;
        end
        if (out_data.cluster_index !== exp_w.cluster_index) begin
          $error("cluster_index exp %0h got %0h", exp_w.cluster_index,
                 out_data.cluster_index);
          errors++;
        end
        if (out_data.unassigned !== exp_w.unassigned) begin
          $error("unassigned exp %0h got %0h", exp_w.unassigned, out_data.unassigned);
          errors++;
        end
        if (out_data.centroid_value !== exp_w.centroid_value) begin
          $error("centroid_value exp %0h got %0h", exp_w.centroid_value,
                 out_data.centroid_value);
          errors++;
        end
        if (out_data.centroid_id !== exp_w.centroid_id) begin
          $error("centroid_id exp %0h got %0h", exp_w.centroid_id, out_data.centroid_id);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    out_t none;
    none = '0;
    for (int i = 0; i < 256; i++) begin
      asg_none[i] = 1'b1;
      asg[i] = 0;
      pid[i] = 0;
      for (int c = 0; c < 64; c++) begin
        pts[i][c] = 0;
        pt_ok[i][c] = 1'b0;
      end
    end
    for (int j = 0; j < 16; j++) begin
      cid[j] = 0;
      for (int c = 0; c < 64; c++) begin
        cen[j][c] = 0;
        cen_ok[j][c] = 1'b0;
      end
    end

    // points: origin, far corner sharing a centroid id, a tie, a near point
    add_row(mk_req(REQ_RD_ASSIGN, 8'd0, 6'd0, 16'd0, 16'd0), 1'b1, mk_resp(0, 0, 1));
    add_row(mk_req(REQ_WR_POINT, 8'd4, 6'd0, 16'd1, 16'd1), 1'b1, mk_resp(1, 0, 0));
    add_row(mk_req(REQ_WR_POINT, 8'd0, 6'd2, 16'd1, 16'd1), 1'b1, mk_resp(1, 0, 0));
    add_row(mk_req(REQ_WR_CENT, 8'h12, 6'd0, 16'd1, 16'd1), 1'b1, mk_resp(1, 0, 0));
    add_row(mk_req(REQ_RD_CENT, 8'h03, 6'd0, 16'd0, 16'd0), 1'b1, mk_resp(1, 0, 0));
    add_row(mk_req(REQ_BAD5, 8'hFF, 6'h3F, 16'hFFFF, 16'hFFFF), 1'b1, none);
    add_row(mk_req(REQ_BAD7, 8'hFF, 6'h3F, 16'hFFFF, 16'hFFFF), 1'b1, none);
    add_row(mk_req(REQ_WR_POINT, 8'd0, 6'd0, 16'd0, 16'd0), 1'b1, none);
    add_row(mk_req(REQ_WR_POINT, 8'd0, 6'd1, 16'd0, 16'd0), 1'b1, none);
    add_row(mk_req(REQ_WR_POINT, 8'd1, 6'd0, 16'hFFFF, 16'hFFFF), 1'b1, none);
    add_row(mk_req(REQ_WR_POINT, 8'd1, 6'd1, 16'hFFFF, 16'hFFFF), 1'b1, none);
    add_row(mk_req(REQ_WR_POINT, 8'd2, 6'd0, 16'd10, 16'd0), 1'b1, none);
    add_row(mk_req(REQ_WR_POINT, 8'd2, 6'd1, 16'd10, 16'd0), 1'b1, none);
    add_row(mk_req(REQ_WR_POINT, 8'd3, 6'd0, 16'd5, 16'd3), 1'b1, none);
    add_row(mk_req(REQ_WR_POINT, 8'd3, 6'd1, 16'd5, 16'd3), 1'b1, none);
    add_row(mk_req(REQ_WR_CENT, 8'h00, 6'd0, 16'd0, 16'hFFFF), 1'b1, none);
    add_row(mk_req(REQ_WR_CENT, 8'h00, 6'd1, 16'd0, 16'hFFFF), 1'b1, none);
    add_row(mk_req(REQ_WR_CENT, 8'hF1, 6'd0, 16'd20, 16'd9), 1'b1, none);
    add_row(mk_req(REQ_WR_CENT, 8'hF1, 6'd1, 16'd20, 16'd9), 1'b1, none);
    add_row(mk_req(REQ_RUN, 8'd0, 6'd0, 16'd0, 16'd0), 1'b1, none);
    for (int i = 0; i < 4; i++)
      add_row(mk_req(REQ_RD_ASSIGN, 8'(i), 6'd0, 16'd0, 16'd0), 1'b0, none);
    add_row(mk_req(REQ_RD_CENT, 8'h01, 6'd0, 16'd0, 16'd0), 1'b0, none);
    add_row(mk_req(REQ_RD_CENT, 8'h00, 6'd1, 16'd0, 16'd0), 1'b0, none);

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send(table_rows[0].req, table_rows[0].known, table_rows[0].want);
    drain();
    set_regs(4, 2, 2, 2);
    for (int i = 1; i < table_rows.size(); i++)
      send(table_rows[i].req, table_rows[i].known, table_rows[i].want);

    random_phase(4, 2, 2, 2, 50);
    hold_at = 10;
    random_phase(16, 4, 4, 3, 100);
    hold_at = -1;
    random_phase(256, 1, 1, 1, 60);
    random_phase(8, 16, 2, 2, 80);
    random_phase(1, 1, 64, 2, 50);
    random_phase(6, 3, 1, 64, 60);
    drain();
    quiet = 1'b1;
    random_phase(12, 5, 3, 4, 100);
    drain();

    $display("%0d result words checked over %0d register settings, %0d runs",
             words, settings, runs);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/kml_pkg.sv
src/kml_div.sv
src/kml_dpath.sv
src/kml_ctrl.sv
src/kmeans_lloyd_clustering.sv
sim/kmeans_lloyd_clustering_test.sv
